// ===== rtl/rsamx_pkg.sv =====
package rsamx_pkg;

   localparam int DATA_W  = 16;
   localparam int CNT_W   = $clog2(DATA_W);
   localparam int OP_W    = 3;
   localparam int CSR_A_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_ENCRYPT  = 3'd0;
   localparam logic [OP_W-1:0] OP_PRIV_POW = 3'd1;
   localparam logic [OP_W-1:0] OP_VERIFY   = 3'd2;
   localparam logic [OP_W-1:0] OP_MASK     = 3'd3;
   localparam logic [OP_W-1:0] OP_UNMASK   = 3'd4;
   localparam logic [OP_W-1:0] OP_UNSIGN   = 3'd5;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_PUB_EXP  = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_PRIV_EXP = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_MODULUS  = 2'd2;

   localparam logic [DATA_W-1:0] PUB_EXP_RST  = DATA_W'(3);
   localparam logic [DATA_W-1:0] PRIV_EXP_RST = DATA_W'(1);
   localparam logic [DATA_W-1:0] MODULUS_RST  = '0;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
   } req_word_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              error;
   } rsp_word_type;

endpackage

// ===== rtl/rsa_modexp_blind_sign_engine.sv =====
// Channel | Ports                          | Direction | Word
// request | req_valid, req_stall, req_data | in        | op, operand_a, operand_b
// result  | rsp_valid, rsp_stall, rsp_data | out       | value, error
// config  | csr_we, csr_index, csr_wdata   | in        | pub/priv exponent, modulus
//
// One word at a time. Each modular multiply runs on the shared shift-add
// unit and each divide on the divider; a power is up to 2*W multiplies,
// an inverse up to ~1.5*W Euclid steps of one divide plus one multiply.
// Modulus below 2 or an unknown op goes straight to the done state.
// Synchronous reset clears control and loads register defaults.
// req_stall is high while a word is in work; a finished result waits in
// the output register and the next request may be taken meanwhile.
module rsa_modexp_blind_sign_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rsamx_pkg::req_word_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rsamx_pkg::rsp_word_type             rsp_data,
   input  logic                                csr_we,
   input  logic [rsamx_pkg::CSR_A_W-1:0]       csr_index,
   input  logic [rsamx_pkg::DATA_W-1:0]        csr_wdata
);
   localparam int W  = rsamx_pkg::DATA_W;
   localparam int CW = rsamx_pkg::CNT_W;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_RED_A   = 9'b000000010,
      ST_RED_B   = 9'b000000100,
      ST_INV_DIV = 9'b000001000,
      ST_INV_MUL = 9'b000010000,
      ST_POW_MUL = 9'b000100000,
      ST_POW_SQ  = 9'b001000000,
      ST_FIN_MUL = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [W-1:0] pub_ff, priv_ff, mod_ff;

   // working set for one word
   logic [rsamx_pkg::OP_W-1:0] op_ff, op_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in, n_ff, n_in;
   logic [W-1:0] ar_ff, ar_in, base_ff, base_in, acc_ff, acc_in;
   logic [W-1:0] exp_ff, exp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0] r_ff, r_in, nr_ff, nr_in, t_ff, t_in, nt_ff, nt_in;
   logic [W-1:0] q_ff, q_in, rn_ff, rn_in;
   logic [W-1:0] val_ff, val_in;
   logic         err_ff, err_in;
   logic         launch_ff, launch_in;

   // result register
   rsamx_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // shared units
   logic [W-1:0] mx, my, prod, dnum, dden, quo, rem;
   logic         mul_done, div_done;
   logic [W-1:0] sub_res;
   logic         accept, out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // operand select for the multiplier and the divider
   always_comb begin
      mx   = '0;
      my   = '0;
      dnum = '0;
      dden = '0;
      unique case (state_ff)
         ST_POW_MUL: begin mx = acc_ff;  my = base_ff; end
         ST_POW_SQ:  begin mx = base_ff; my = base_ff; end
         ST_INV_MUL: begin mx = q_ff;    my = nt_ff;   end
         ST_FIN_MUL: begin mx = ar_ff;   my = acc_ff;  end
         ST_RED_A:   begin dnum = a_ff;  dden = n_ff;  end
         ST_RED_B:   begin dnum = b_ff;  dden = n_ff;  end
         ST_INV_DIV: begin dnum = r_ff;  dden = nr_ff; end
         default: ;
      endcase
   end

   rsamx_mulmod u_mul (
      .clock (clock),
      .reset (reset),
      .start (launch_ff && (state_ff == ST_POW_MUL || state_ff == ST_POW_SQ ||
                            state_ff == ST_INV_MUL || state_ff == ST_FIN_MUL)),
      .x     (mx),
      .y     (my),
      .n     (n_ff),
      .done  (mul_done),
      .prod  (prod)
   );

   rsamx_divu u_div (
      .clock (clock),
      .reset (reset),
      .start (launch_ff && (state_ff == ST_RED_A || state_ff == ST_RED_B ||
                            state_ff == ST_INV_DIV)),
      .num   (dnum),
      .den   (dden),
      .done  (div_done),
      .quo   (quo),
      .rem   (rem)
   );

   // Euclid coefficient update: (t - q*nt) mod n
   assign sub_res = (t_ff >= prod) ? t_ff - prod : t_ff + (n_ff - prod);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      n_in      = n_ff;
      ar_in     = ar_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      exp_in    = exp_ff;
      cnt_in    = cnt_ff;
      r_in      = r_ff;
      nr_in     = nr_ff;
      t_in      = t_ff;
      nt_in     = nt_ff;
      q_in      = q_ff;
      rn_in     = rn_ff;
      val_in    = val_ff;
      err_in    = err_ff;
      launch_in = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_data.op;
               a_in   = req_data.operand_a;
               b_in   = req_data.operand_b;
               n_in   = mod_ff;
               val_in = '0;
               err_in = 1'b0;
               if (mod_ff < W'(2)) begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else if (req_data.op > rsamx_pkg::OP_UNSIGN) begin
                  state_in = ST_DONE;
               end else begin
                  state_in  = ST_RED_A;
                  launch_in = 1'b1;
               end
            end
         end
         ST_RED_A: begin
            if (div_done) begin
               ar_in     = rem;
               state_in  = ST_RED_B;
               launch_in = 1'b1;
            end
         end
         ST_RED_B: begin
            if (div_done) begin
               acc_in = W'(1);
               cnt_in = CW'(W - 1);
               unique case (op_ff)
                  rsamx_pkg::OP_ENCRYPT, rsamx_pkg::OP_PRIV_POW: begin
                     base_in   = ar_ff;
                     exp_in    = (op_ff == rsamx_pkg::OP_ENCRYPT) ? pub_ff : priv_ff;
                     state_in  = exp_in[0] ? ST_POW_MUL : ST_POW_SQ;
                     launch_in = 1'b1;
                  end
                  rsamx_pkg::OP_VERIFY, rsamx_pkg::OP_MASK: begin
                     base_in   = rem;
                     exp_in    = pub_ff;
                     state_in  = pub_ff[0] ? ST_POW_MUL : ST_POW_SQ;
                     launch_in = 1'b1;
                  end
                  default: begin
                     // inverse: r = n, nr = b mod n, t = 0, nt = 1
                     r_in  = n_ff;
                     nr_in = rem;
                     t_in  = '0;
                     nt_in = W'(1);
                     if (rem == '0) begin
                        err_in   = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        state_in  = ST_INV_DIV;
                        launch_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_INV_DIV: begin
            if (div_done) begin
               // quotient can equal n only on the first step; it is 0 mod n
               q_in      = (quo == n_ff) ? '0 : quo;
               rn_in     = rem;
               state_in  = ST_INV_MUL;
               launch_in = 1'b1;
            end
         end
         ST_INV_MUL: begin
            if (mul_done) begin
               t_in  = nt_ff;
               nt_in = sub_res;
               r_in  = nr_ff;
               nr_in = rn_ff;
               if (rn_ff != '0) begin
                  state_in  = ST_INV_DIV;
                  launch_in = 1'b1;
               end else if (nr_ff != W'(1)) begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else if (op_ff == rsamx_pkg::OP_UNMASK) begin
                  base_in   = nt_ff;
                  acc_in    = W'(1);
                  exp_in    = pub_ff;
                  cnt_in    = CW'(W - 1);
                  state_in  = pub_ff[0] ? ST_POW_MUL : ST_POW_SQ;
                  launch_in = 1'b1;
               end else begin
                  acc_in    = nt_ff;
                  state_in  = ST_FIN_MUL;
                  launch_in = 1'b1;
               end
            end
         end
         ST_POW_MUL: begin
            if (mul_done) begin
               acc_in    = prod;
               state_in  = ST_POW_SQ;
               launch_in = 1'b1;
            end
         end
         ST_POW_SQ: begin
            if (mul_done) begin
               base_in = prod;
               if (cnt_ff != '0) begin
                  cnt_in    = cnt_ff - 1'b1;
                  exp_in    = exp_ff >> 1;
                  state_in  = exp_ff[1] ? ST_POW_MUL : ST_POW_SQ;
                  launch_in = 1'b1;
               end else if (op_ff == rsamx_pkg::OP_VERIFY) begin
                  // unreduced operand a, so a >= n never matches
                  val_in   = (acc_ff == a_ff) ? W'(1) : '0;
                  state_in = ST_DONE;
               end else if (op_ff == rsamx_pkg::OP_MASK || op_ff == rsamx_pkg::OP_UNMASK) begin
                  state_in  = ST_FIN_MUL;
                  launch_in = 1'b1;
               end else begin
                  val_in   = acc_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_FIN_MUL: begin
            if (mul_done) begin
               val_in   = prod;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in.value = val_ff;
               rsp_in.error = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pub_ff       <= rsamx_pkg::PUB_EXP_RST;
         priv_ff      <= rsamx_pkg::PRIV_EXP_RST;
         mod_ff       <= rsamx_pkg::MODULUS_RST;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               rsamx_pkg::CSR_PUB_EXP:  pub_ff  <= csr_wdata;
               rsamx_pkg::CSR_PRIV_EXP: priv_ff <= csr_wdata;
               rsamx_pkg::CSR_MODULUS:  mod_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      n_ff    <= n_in;
      ar_ff   <= ar_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      exp_ff  <= exp_in;
      cnt_ff  <= cnt_in;
      r_ff    <= r_in;
      nr_ff   <= nr_in;
      t_ff    <= t_in;
      nt_ff   <= nt_in;
      q_ff    <= q_in;
      rn_ff   <= rn_in;
      val_ff  <= val_in;
      err_ff  <= err_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== rtl/rsamx_mulmod.sv =====
// Shift-add modular multiplier, one multiplier bit per cycle, MSB first.
// Needs x < n; result valid with done.
module rsamx_mulmod (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsamx_pkg::DATA_W-1:0]     x,
   input  logic [rsamx_pkg::DATA_W-1:0]     y,
   input  logic [rsamx_pkg::DATA_W-1:0]     n,
   output logic                             done,
   output logic [rsamx_pkg::DATA_W-1:0]     prod
);
   localparam int W = rsamx_pkg::DATA_W;

   logic [W-1:0]                acc_ff, acc_in;
   logic [W-1:0]                x_ff, y_ff, n_ff;
   logic [rsamx_pkg::CNT_W-1:0] cnt_ff;
   logic                        busy_ff, done_ff;
   logic [W:0]                  dbl, dbl_r, sum, sum_r;

   always_comb begin
      dbl    = {acc_ff, 1'b0};
      dbl_r  = (dbl >= {1'b0, n_ff}) ? dbl - {1'b0, n_ff} : dbl;
      sum    = dbl_r + (y_ff[W-1] ? {1'b0, x_ff} : '0);
      sum_r  = (sum >= {1'b0, n_ff}) ? sum - {1'b0, n_ff} : sum;
      acc_in = sum_r[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start)
            busy_ff <= 1'b1;
         else if (busy_ff && (cnt_ff == '0))
            busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         x_ff   <= x;
         y_ff   <= y;
         n_ff   <= n;
         cnt_ff <= rsamx_pkg::CNT_W'(W - 1);
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         y_ff   <= {y_ff[W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

// ===== rtl/rsamx_divu.sv =====
// Restoring divider, one quotient bit per cycle. den must be nonzero.
module rsamx_divu (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rsamx_pkg::DATA_W-1:0] num,
   input  logic [rsamx_pkg::DATA_W-1:0] den,
   output logic                         done,
   output logic [rsamx_pkg::DATA_W-1:0] quo,
   output logic [rsamx_pkg::DATA_W-1:0] rem
);
   localparam int W = rsamx_pkg::DATA_W;

   logic [W-1:0]                qn_ff, rem_ff, den_ff;
   logic [rsamx_pkg::CNT_W-1:0] cnt_ff;
   logic                        busy_ff, done_ff;
   logic [W:0]                  trial;
   logic                        ge;

   always_comb begin
      trial = {rem_ff, qn_ff[W-1]};
      ge    = (trial >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start)
            busy_ff <= 1'b1;
         else if (busy_ff && (cnt_ff == '0))
            busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         qn_ff  <= num;
         rem_ff <= '0;
         den_ff <= den;
         cnt_ff <= rsamx_pkg::CNT_W'(W - 1);
      end else if (busy_ff) begin
         qn_ff  <= {qn_ff[W-2:0], ge};
         rem_ff <= ge ? W'(trial - {1'b0, den_ff}) : trial[W-1:0];
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign quo  = qn_ff;
   assign rem  = rem_ff;
endmodule

// ===== rtl/rsamx_checker.sv =====
module rsamx_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input rsamx_pkg::req_word_type       req_data,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input rsamx_pkg::rsp_word_type       rsp_data,
   input logic                          csr_we,
   input logic [rsamx_pkg::CSR_A_W-1:0] csr_index,
   input logic [rsamx_pkg::DATA_W-1:0]  csr_wdata
);
   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");

   // one word in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // an error result carries value zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.value == '0)
      else $error("error result with nonzero value");

   // reset leaves the block idle and empty
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");
endmodule

bind rsa_modexp_blind_sign_engine rsamx_checker u_rsamx_checker (.*);
